/* rtl/rmf_pkg.sv */
// Shared constants and item types for the RGB 3x3 median filter.
package rmf_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int CHANNELS    = 3;
    localparam int SAMPLE_BITS = 8;
    localparam int ROW_SAMPLES = MAX_WIDTH * CHANNELS;
    localparam int TAPS        = 2 * CHANNELS + 1;

    // Counter and field widths
    localparam int COL_BITS    = $clog2(ROW_SAMPLES + 1);
    localparam int POS_BITS    = COL_BITS + 1;
    localparam int ROW_BITS    = 17;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int CHAN_BITS   = 2;

    // Configuration port
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // Input item
    typedef struct packed
    {
        sample_t sample;
        logic    fill;
    } in_item_t;

    // Result item
    typedef struct packed
    {
        sample_t              median_value;
        logic [CHAN_BITS-1:0] channel;
        logic                 end_of_row;
        logic                 end_of_frame;
    } out_item_t;

    // Position information that travels with an item down the pipeline
    typedef struct packed
    {
        logic                 res;
        logic                 top_out;
        logic                 bot_out;
        logic                 left_out;
        logic                 right_out;
        logic [CHAN_BITS-1:0] channel;
        logic                 eor;
        logic                 eof;
    } pos_tag_t;

endpackage

/* rtl/rgb_median_3x3_filter.sv */
// Streaming 3x3 median filter over interleaved R,G,B samples.
// Throughput: one item per cycle; the whole pipeline halts only while a result waits.
// Path: the item that completes a window passes stage 1, the window (stage 2), the sorted rows
//   (stage 3) and the result register; it arrives row_len + 3 items after its center sample.
// The two row stores are 3072 x 8 memories with one registered read per item.
// Reset clears counters, window and valid bits; width and height return to 1.
module rgb_median_3x3_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample channel
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  rmf_pkg::in_item_t                 pix,
    // Result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output rmf_pkg::out_item_t                res,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rmf_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [rmf_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [rmf_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import rmf_pkg::*;

    // Compare-exchange helpers for the median network
    function automatic sample_t min2(input sample_t a, input sample_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic sample_t max2(input sample_t a, input sample_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Configuration registers
    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [HEIGHT_BITS-1:0] image_height_reg;
    cfg_reg_t               cfg_sel;

    // Input position counters
    logic [COL_BITS-1:0]    input_column_reg, input_column_next;
    logic [ROW_BITS-1:0]    input_row_reg, input_row_next;
    logic [CHAN_BITS-1:0]   phase_reg, phase_next;

    // Stage 1: item waiting for its row store read data
    logic                   s1_valid_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    sample_t                s1_sample_reg;
    pos_tag_t               s1_tag_reg;
    sample_t                top_rd_reg, mid_rd_reg;

    // Stage 2: window of the newest item
    sample_t                win_reg [3][TAPS];
    logic                   s2_res_reg;
    pos_tag_t               s2_tag_reg;

    // Stage 3: sorted rows
    sample_t                lo_reg [3];
    sample_t                md_reg [3];
    sample_t                hi_reg [3];
    logic                   s3_res_reg;
    pos_tag_t               s3_tag_reg;

    // Result register
    logic                   res_valid_reg;
    out_item_t              res_reg;

    // Row stores
    sample_t                older_mem [ROW_SAMPLES];
    sample_t                newer_mem [ROW_SAMPLES];

    // Combinational signals
    logic                   en;
    logic                   accept;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [COL_BITS-1:0]    len;
    logic [COL_BITS-1:0]    col0;
    logic [CHAN_BITS-1:0]   phase0;
    logic                   col_hi;
    logic                   row_under;
    logic [ROW_BITS-1:0]    r_val;
    logic [POS_BITS-1:0]    c_pos;
    logic [POS_BITS-1:0]    col_inc;
    pos_tag_t               tag0;
    sample_t                v0;
    sample_t                nb [3][3];
    sample_t                srt_lo [3];
    sample_t                srt_md [3];
    sample_t                srt_hi [3];
    sample_t                x_lo, x_hi, y_lo, y_hi;
    sample_t                median;

    // Handshake: the whole pipeline advances unless a result is held
    assign en        = !res_valid_reg || !res_stall;
    assign pix_stall = !en;
    assign accept    = pix_valid && en;

    // Configuration access
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[PADDR_BITS-1]);

    always_comb
    begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_BITS'(1);
            image_height_reg <= HEIGHT_BITS'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_sel)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_BITS-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // Clamp geometry and locate the output position of the incoming item
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = WIDTH_BITS'(1);
        else if (image_width_reg > WIDTH_BITS'(MAX_WIDTH))
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        else
            w_eff = image_width_reg;
        h_eff = (image_height_reg == '0) ? HEIGHT_BITS'(1) : image_height_reg;
        len   = COL_BITS'(w_eff * CHANNELS);

        if (input_column_reg >= COL_BITS'(ROW_SAMPLES))
        begin
            col0   = '0;
            phase0 = '0;
        end
        else
        begin
            col0   = input_column_reg;
            phase0 = phase_reg;
        end

        // Center lies one pixel back; the first pixel of a row reaches into the row before
        col_hi = col0 >= COL_BITS'(CHANNELS);
        if (col_hi)
        begin
            row_under = input_row_reg == '0;
            r_val     = input_row_reg - ROW_BITS'(1);
            c_pos     = POS_BITS'(col0) - POS_BITS'(CHANNELS);
        end
        else
        begin
            row_under = input_row_reg < ROW_BITS'(2);
            r_val     = input_row_reg - ROW_BITS'(2);
            c_pos     = POS_BITS'(col0) + POS_BITS'(len) - POS_BITS'(CHANNELS);
        end

        tag0.res       = !row_under && (r_val < ROW_BITS'(h_eff)) && (c_pos < POS_BITS'(len));
        tag0.top_out   = r_val == '0;
        tag0.bot_out   = r_val == ROW_BITS'(h_eff) - ROW_BITS'(1);
        tag0.left_out  = c_pos < POS_BITS'(CHANNELS);
        tag0.right_out = (c_pos + POS_BITS'(CHANNELS)) >= POS_BITS'(len);
        tag0.channel   = phase0;
        tag0.eor       = c_pos == POS_BITS'(len) - POS_BITS'(1);
        tag0.eof       = tag0.res && tag0.bot_out && tag0.eor;

        v0 = pix.fill ? '0 : pix.sample;
    end

    // Advance the position counters
    always_comb
    begin
        col_inc           = POS_BITS'(col0) + POS_BITS'(1);
        input_column_next = input_column_reg;
        input_row_next    = input_row_reg;
        phase_next        = phase_reg;
        if (accept)
        begin
            priority if (tag0.eof)
            begin
                input_column_next = '0;
                input_row_next    = '0;
                phase_next        = '0;
            end
            else if (col_inc >= POS_BITS'(len))
            begin
                input_column_next = '0;
                input_row_next    = input_row_reg + ROW_BITS'(1);
                phase_next        = '0;
            end
            else
            begin
                input_column_next = col_inc[COL_BITS-1:0];
                phase_next        = (phase0 == CHAN_BITS'(CHANNELS - 1)) ? '0
                                                                         : phase0 + CHAN_BITS'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_column_reg <= '0;
            input_row_reg    <= '0;
            phase_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s2_res_reg       <= 1'b0;
            s3_res_reg       <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            input_column_reg <= input_column_next;
            input_row_reg    <= input_row_next;
            phase_reg        <= phase_next;
            if (en)
            begin
                s1_valid_reg  <= accept;
                s2_res_reg    <= s1_valid_reg && s1_tag_reg.res;
                s3_res_reg    <= s2_res_reg;
                res_valid_reg <= s3_res_reg;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg    <= col0;
            s1_sample_reg <= v0;
            s1_tag_reg    <= tag0;
        end
    end

    // Row stores: read at the new item's column, write back the previous item's column.
    // Consecutive items never share a column, so no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
            older_mem[s1_col_reg] <= mid_rd_reg;
        if (en)
            top_rd_reg <= older_mem[col0];
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
            newer_mem[s1_col_reg] <= s1_sample_reg;
        if (en)
            mid_rd_reg <= newer_mem[col0];
    end

    // Shift the window by one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
                for (int k = 0; k < TAPS; k++)
                    win_reg[a][k] <= '0;
        end
        else if (en && s1_valid_reg)
        begin
            for (int a = 0; a < 3; a++)
                for (int k = 0; k < TAPS - 1; k++)
                    win_reg[a][k] <= win_reg[a][k+1];
            win_reg[0][TAPS-1] <= top_rd_reg;
            win_reg[1][TAPS-1] <= mid_rd_reg;
            win_reg[2][TAPS-1] <= s1_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
            s2_tag_reg <= s1_tag_reg;
    end

    // Zero neighbors outside the image, then sort each row of three
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ((a == 0 && s2_tag_reg.top_out) || (a == 2 && s2_tag_reg.bot_out) ||
                    (k == 0 && s2_tag_reg.left_out) || (k == 2 && s2_tag_reg.right_out))
                    nb[a][k] = '0;
                else
                    nb[a][k] = win_reg[a][k*CHANNELS];
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            x_lo      = min2(nb[a][0], nb[a][1]);
            x_hi      = max2(nb[a][0], nb[a][1]);
            y_lo      = min2(x_hi, nb[a][2]);
            y_hi      = max2(x_hi, nb[a][2]);
            srt_lo[a] = min2(x_lo, y_lo);
            srt_md[a] = max2(x_lo, y_lo);
            srt_hi[a] = y_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= srt_lo[a];
                md_reg[a] <= srt_md[a];
                hi_reg[a] <= srt_hi[a];
            end
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Median of nine: median of (max of lows, median of middles, min of highs)
    assign median = med3(max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]),
                         med3(md_reg[0], md_reg[1], md_reg[2]),
                         min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]));

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.median_value <= median;
            res_reg.channel      <= s3_tag_reg.channel;
            res_reg.end_of_row   <= s3_tag_reg.eor;
            res_reg.end_of_frame <= s3_tag_reg.eof;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/rmf_checker.sv */
// Port-level checks for the RGB 3x3 median filter, bound to its top level.
module rmf_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                pix_stall,
    input logic                res_valid,
    input logic                res_stall,
    input rmf_pkg::out_item_t  res
);
    import rmf_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed or vanished");

    // Stall the sample side only while a result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && res_stall) |-> !pix_stall)
    else $error("sample channel stalled without a held result");

    // Channel code stays within the color channels
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.channel != CHAN_BITS'(3))
    else $error("result channel out of range");

    // Frame end falls on a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.end_of_frame |-> res.end_of_row)
    else $error("frame end without row end");

endmodule

bind rgb_median_3x3_filter rmf_checker u_rmf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
